// ===== hw/rtl/lsq_pkg.sv =====
// ----------------------------------------------------------------------------
// lsq_pkg
// Shared codes, control structs and helper functions of the load/store queue.
// ----------------------------------------------------------------------------
package lsq_pkg;

	localparam int TAG_W  = 5;
	localparam int REG_W  = 5;
	localparam int WORD_W = 32;

	localparam logic [1:0] CMD_ISSUE = 2'd0;
	localparam logic [1:0] CMD_BCAST = 2'd1;
	localparam logic [1:0] CMD_COMMIT = 2'd2;
	localparam logic [1:0] CMD_DONE  = 2'd3;

	localparam logic [2:0] OP_SB  = 3'd0;
	localparam logic [2:0] OP_SH  = 3'd1;
	localparam logic [2:0] OP_SW  = 3'd2;
	localparam logic [2:0] OP_LB  = 3'd3;
	localparam logic [2:0] OP_LH  = 3'd4;
	localparam logic [2:0] OP_LW  = 3'd5;
	localparam logic [2:0] OP_LBU = 3'd6;
	localparam logic [2:0] OP_LHU = 3'd7;

	localparam logic [1:0] SIZE_B = 2'd0;
	localparam logic [1:0] SIZE_H = 2'd1;
	localparam logic [1:0] SIZE_W = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_MISMATCH = 3'd2;
	localparam logic [2:0] ST_NOT_RDY  = 3'd3;
	localparam logic [2:0] ST_BUSY     = 3'd4;
	localparam logic [2:0] ST_NOTHING  = 3'd5;

	typedef struct packed {
		logic       issue;
		logic       bcast;
		logic       start;
		logic       retire;
		logic [2:0] status;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic tag_match;
		logic head_ready;
		logic started;
	} stat_t;

	function automatic logic [1:0] op_size(input logic [2:0] op);
		logic [1:0] s;
		unique case (op)
			OP_SB, OP_LB, OP_LBU: s = SIZE_B;
			OP_SH, OP_LH, OP_LHU: s = SIZE_H;
			default:              s = SIZE_W;
		endcase
		return s;
	endfunction

	function automatic logic [WORD_W-1:0] extend_load(input logic [2:0] op,
			input logic [WORD_W-1:0] raw);
		logic [WORD_W-1:0] r;
		unique case (op)
			OP_LB:   r = {{24{raw[7]}}, raw[7:0]};
			OP_LH:   r = {{16{raw[15]}}, raw[15:0]};
			OP_LBU:  r = {24'd0, raw[7:0]};
			OP_LHU:  r = {16'd0, raw[15:0]};
			default: r = raw;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/lsq_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsq_ctrl
// Handshake state machine and command decode of the load/store queue.
// ----------------------------------------------------------------------------
module lsq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        command,
	input  logic              mem_busy,
	input  lsq_pkg::stat_t    stat,
	output logic              accept,
	output lsq_pkg::cmd_t     cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_HOLD = 1'b1;

	logic st_q;

	assign out_valid = (st_q == ST_HOLD);
	assign in_stall  = out_valid && out_stall;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else if (accept) begin
			st_q <= ST_HOLD;
		end else if (!out_stall) begin
			st_q <= ST_IDLE;
		end
	end

	always_comb begin
		cmd = '0;
		unique case (command)
			lsq_pkg::CMD_ISSUE: begin
				if (stat.full) begin
					cmd.status = lsq_pkg::ST_FULL;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			lsq_pkg::CMD_BCAST: begin
				cmd.bcast = 1'b1;
			end
			lsq_pkg::CMD_COMMIT: begin
				priority if (stat.empty) begin
					cmd.status = lsq_pkg::ST_NOTHING;
				end else if (!stat.tag_match) begin
					cmd.status = lsq_pkg::ST_MISMATCH;
				end else if (mem_busy) begin
					cmd.status = lsq_pkg::ST_BUSY;
				end else if (!stat.head_ready) begin
					cmd.status = lsq_pkg::ST_NOT_RDY;
				end else begin
					cmd.start = 1'b1;
				end
			end
			default: begin
				if (stat.empty || !stat.started) begin
					cmd.status = lsq_pkg::ST_NOTHING;
				end else begin
					cmd.retire = 1'b1;
				end
			end
		endcase
	end

	a_retire_started: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.retire |-> stat.started && !stat.empty)
		else $error("retire of a head that was not started");
	a_start_ready: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.start |-> stat.tag_match && stat.head_ready && !mem_busy)
		else $error("head started without operands");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

endmodule

// ===== hw/rtl/lsq_dp.sv =====
// ----------------------------------------------------------------------------
// lsq_dp
// Entry storage, pointers, wakeup compare and result registers.
// ----------------------------------------------------------------------------
module lsq_dp #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  lsq_pkg::cmd_t             cmd,
	output lsq_pkg::stat_t            stat,
	input  logic [2:0]                op,
	input  logic [lsq_pkg::TAG_W-1:0] tag,
	input  logic [lsq_pkg::REG_W-1:0] dest_reg,
	input  logic                      data_ready,
	input  logic [lsq_pkg::TAG_W-1:0] data_tag,
	input  logic [31:0]               value,
	input  logic                      is_address,
	input  logic [31:0]               read_data,
	output logic [2:0]                status,
	output logic                      access_valid,
	output logic                      access_write,
	output logic [1:0]                access_size,
	output logic [31:0]               access_addr,
	output logic [31:0]               store_data,
	output logic                      load_valid,
	output logic [31:0]               load_value,
	output logic [lsq_pkg::TAG_W-1:0] load_tag,
	output logic [lsq_pkg::REG_W-1:0] load_dest,
	output logic                      full_res,
	output logic                      head_ready
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	logic [2:0]                e_op_q    [QUEUE_DEPTH];
	logic [lsq_pkg::REG_W-1:0] e_dest_q  [QUEUE_DEPTH];
	logic [lsq_pkg::TAG_W-1:0] e_tag_q   [QUEUE_DEPTH];
	logic [lsq_pkg::TAG_W-1:0] e_wait_q  [QUEUE_DEPTH];
	logic                      e_aok_q   [QUEUE_DEPTH];
	logic                      e_dok_q   [QUEUE_DEPTH];
	logic [31:0]               e_data_q  [QUEUE_DEPTH];
	logic [31:0]               e_addr_q  [QUEUE_DEPTH];

	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] occ_q;
	logic             started_q;

	logic [2:0]  h_op;
	logic [1:0]  h_size;
	logic [31:0] h_data;
	logic [31:0] st_word;
	logic        is_store;
	logic        st_take;
	logic        ld_take;

	assign h_op     = e_op_q[head_q];
	assign h_size   = lsq_pkg::op_size(h_op);
	assign h_data   = e_data_q[head_q];
	assign is_store = (h_op == lsq_pkg::OP_SB) || (h_op == lsq_pkg::OP_SH) ||
		(h_op == lsq_pkg::OP_SW);
	assign st_take  = cmd.retire && is_store;
	assign ld_take  = cmd.retire && !is_store;

	always_comb begin
		unique case (h_size)
			lsq_pkg::SIZE_B: st_word = {24'd0, h_data[7:0]};
			lsq_pkg::SIZE_H: st_word = {16'd0, h_data[15:0]};
			default:         st_word = h_data;
		endcase
	end

	always_comb begin
		stat.empty      = (occ_q == '0);
		stat.full       = (occ_q == FULL_CNT);
		stat.tag_match  = (e_tag_q[head_q] == tag);
		stat.head_ready = !stat.empty && e_aok_q[head_q] && e_dok_q[head_q];
		stat.started    = started_q;
	end

	// state only moves on accept, so these track the last item while it waits
	assign full_res   = stat.full;
	assign head_ready = stat.head_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			occ_q     <= '0;
			started_q <= 1'b0;
		end else if (accept) begin
			if (cmd.issue) begin
				tail_q <= (tail_q == LAST) ? '0 : tail_q + 1'b1;
				occ_q  <= occ_q + 1'b1;
			end
			if (cmd.start) begin
				started_q <= 1'b1;
			end
			if (cmd.retire) begin
				head_q    <= (head_q == LAST) ? '0 : head_q + 1'b1;
				occ_q     <= occ_q - 1'b1;
				started_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (cmd.issue && tail_q == PTR_W'(i)) begin
					e_op_q[i]   <= op;
					e_dest_q[i] <= dest_reg;
					e_tag_q[i]  <= tag;
					e_wait_q[i] <= data_tag;
					e_aok_q[i]  <= 1'b0;
					e_dok_q[i]  <= (op > lsq_pkg::OP_SW) || data_ready;
					e_data_q[i] <= value;
				end
				if (cmd.bcast) begin
					if (is_address) begin
						if (!e_aok_q[i] && e_tag_q[i] == tag) begin
							e_addr_q[i] <= value;
							e_aok_q[i]  <= 1'b1;
						end
					end else if (!e_dok_q[i] && e_wait_q[i] == tag) begin
						e_data_q[i] <= value;
						e_dok_q[i]  <= 1'b1;
					end
				end
			end
		end
	end

	// result registers; zero the access fields unless the head retires
	always_ff @(posedge clk) begin
		if (accept) begin
			status       <= cmd.status;
			access_valid <= cmd.retire;
			access_write <= st_take;
			access_size  <= cmd.retire ? h_size : 2'd0;
			access_addr  <= cmd.retire ? e_addr_q[head_q] : 32'd0;
			store_data   <= st_take ? st_word : 32'd0;
			load_valid   <= ld_take;
			load_value   <= ld_take ? lsq_pkg::extend_load(h_op, read_data) : 32'd0;
			load_tag     <= ld_take ? e_tag_q[head_q] : '0;
			load_dest    <= ld_take ? e_dest_q[head_q] : '0;
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= FULL_CNT)
		else $error("occupancy beyond depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == '0 || occ_q == FULL_CNT || head_q != tail_q)
		else $error("pointers disagree with occupancy");
	a_started_live: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> occ_q != '0)
		else $error("started head on empty queue");

endmodule

// ===== hw/rtl/load_store_queue_unit.sv =====
// ----------------------------------------------------------------------------
// load_store_queue_unit
// In-order load/store queue with tag wakeup, commit start and memory retire.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) carries one item per event: issue,
//   broadcast, commit or memory done, selected by command. Every accepted item
//   yields exactly one result item on the output channel (out_valid/out_stall).
//   An item is decoded and applied to the queue in the cycle it is accepted;
//   its result is registered and shows in the next cycle.
//   Throughput is one item per cycle while the receiver takes results; the
//   single output register sets that figure.
//   When the receiver stalls, the result holds and in_stall rises, so no new
//   item enters until the waiting result is taken.
//   full_res and head_ready reflect the queue state after the item shown.
//   Reset empties the queue (pointers and occupancy cleared, no head started)
//   and drops any pending result. Entry storage is not cleared.
// ----------------------------------------------------------------------------
module load_store_queue_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  op,
	input  logic [4:0]  tag,
	input  logic [4:0]  dest_reg,
	input  logic        data_ready,
	input  logic [4:0]  data_tag,
	input  logic [31:0] value,
	input  logic        is_address,
	input  logic        mem_busy,
	input  logic [31:0] read_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        access_valid,
	output logic        access_write,
	output logic [1:0]  access_size,
	output logic [31:0] access_addr,
	output logic [31:0] store_data,
	output logic        load_valid,
	output logic [31:0] load_value,
	output logic [4:0]  load_tag,
	output logic [4:0]  load_dest,
	output logic        full_res,
	output logic        head_ready
);

	logic           accept;
	lsq_pkg::cmd_t  cmd;
	lsq_pkg::stat_t stat;

	lsq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.command   (command),
		.mem_busy  (mem_busy),
		.stat      (stat),
		.accept    (accept),
		.cmd       (cmd)
	);

	lsq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cmd          (cmd),
		.stat         (stat),
		.op           (op),
		.tag          (tag),
		.dest_reg     (dest_reg),
		.data_ready   (data_ready),
		.data_tag     (data_tag),
		.value        (value),
		.is_address   (is_address),
		.read_data    (read_data),
		.status       (status),
		.access_valid (access_valid),
		.access_write (access_write),
		.access_size  (access_size),
		.access_addr  (access_addr),
		.store_data   (store_data),
		.load_valid   (load_valid),
		.load_value   (load_value),
		.load_tag     (load_tag),
		.load_dest    (load_dest),
		.full_res     (full_res),
		.head_ready   (head_ready)
	);

endmodule
